[hw/rtl/pwa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, request types and helpers for the PID block with gain autotune.
// Used by pwa_mul, pwa_div and pid_with_gain_autotune. No dependencies.
package pwa_pkg;

    localparam int GAIN_FRAC_BITS = 16;
    localparam int SUM_W          = 48;
    localparam int DRIVE_LIMIT    = 255;

    localparam int ANGLE_W = 17;
    localparam int ERR_W   = 18;
    localparam int DE_W    = 19;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 32;
    localparam int TG_W    = 24;
    localparam int LIM_W   = 16;
    localparam int DRV_W   = 9;
    localparam int TERM_W  = 64;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int DIV_N_W = 56;
    localparam int DIV_D_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNE   = 2'd3;

    localparam logic signed [TERM_W-1:0] TERM_LIM = 64'sd1 <<< 61;
    localparam logic signed [TERM_W-1:0] SUM_MAX  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam logic signed [TERM_W-1:0] SUM_MIN  = -SUM_MAX - 64'sd1;
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] n;
        logic [DIV_D_W-1:0] d;
    } div_req_t;

    function automatic logic signed [TERM_W-1:0] clamp_term(input logic signed [TERM_W-1:0] v);
        logic signed [TERM_W-1:0] r;
        r = v;
        if (v > TERM_LIM)
            r = TERM_LIM;
        else if (v < -TERM_LIM)
            r = -TERM_LIM;
        return r;
    endfunction

endpackage

[hw/rtl/pid_with_gain_autotune.sv]
`timescale 1ns / 1ps
// PID drive with one-shot gain autotune: sequencer and state registers.
// Depends on pwa_pkg, pwa_mul and pwa_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries angle and elapsed_ms; the
//   output channel (out_valid/out_ready) returns motor_speed and the
//   tuning, tune_finished and zero_interval flags, one result per item.
//   The configuration port writes target_angle, oscillation_limit,
//   test_gain and tune_after_reset (index 0 to 3) on cfg_write; write it
//   only while no item is in flight. Writing tune_after_reset also sets
//   or clears tuning mode.
//   Items are processed one at a time through a shared bit-serial
//   multiplier and a restoring divider. Tuning-mode items compute only
//   the proportional term; normal items add the integral term and, when
//   elapsed_ms is nonzero, the derivative term; the item that ends
//   tuning also computes the new gains. The next item is taken once the
//   previous result sits in the output register.
//   Reset clears the integral and previous error, loads the default
//   configuration, sets gain_p to the default test gain and enters
//   tuning mode. While the receiver stalls, the result is held and the
//   block stops after finishing at most one further item.
module pid_with_gain_autotune
    import pwa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [ANGLE_W-1:0]   angle,
    input  logic [DT_W-1:0]             elapsed_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [DRV_W-1:0]     motor_speed,
    output logic                        tuning,
    output logic                        tune_finished,
    output logic                        zero_interval,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] S_INC   = 5'd1;
    localparam logic [ST_W-1:0] S_INC_W = 5'd2;
    localparam logic [ST_W-1:0] S_P     = 5'd3;
    localparam logic [ST_W-1:0] S_P_W   = 5'd4;
    localparam logic [ST_W-1:0] S_I     = 5'd5;
    localparam logic [ST_W-1:0] S_I_W   = 5'd6;
    localparam logic [ST_W-1:0] S_DM    = 5'd7;
    localparam logic [ST_W-1:0] S_DM_W  = 5'd8;
    localparam logic [ST_W-1:0] S_DV    = 5'd9;
    localparam logic [ST_W-1:0] S_DV_W  = 5'd10;
    localparam logic [ST_W-1:0] S_CHK   = 5'd11;
    localparam logic [ST_W-1:0] S_KP    = 5'd12;
    localparam logic [ST_W-1:0] S_KP_W  = 5'd13;
    localparam logic [ST_W-1:0] S_GI    = 5'd14;
    localparam logic [ST_W-1:0] S_GI_W  = 5'd15;
    localparam logic [ST_W-1:0] S_GD    = 5'd16;
    localparam logic [ST_W-1:0] S_GD_W  = 5'd17;
    localparam logic [ST_W-1:0] S_OUT   = 5'd18;

    localparam logic [TG_W-1:0]  TG_RESET  = 24'd65536;
    localparam logic [LIM_W-1:0] LIM_RESET = 16'd1280;

    // configuration
    logic signed [ANGLE_W-1:0] target_reg, target_next;
    logic [LIM_W-1:0]          limit_reg, limit_next;
    logic [TG_W-1:0]           tgain_reg, tgain_next;
    logic                      tune_cfg_reg, tune_cfg_next;

    // controller state
    logic [ST_W-1:0]           state_reg, state_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [ERR_W-1:0]   last_reg, last_next;
    logic [GAIN_W-1:0]         gp_reg, gp_next;
    logic [GAIN_W-1:0]         gi_reg, gi_next;
    logic [GAIN_W-1:0]         gd_reg, gd_next;
    logic                      tact_reg, tact_next;

    // per-item working registers
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DE_W-1:0]    de_reg, de_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic                      zero_reg, zero_next;
    logic                      was_tun_reg, was_tun_next;
    logic                      fin_reg, fin_next;
    logic signed [TERM_W-1:0]  u_reg, u_next;
    logic [TG_W-1:0]           kp_reg, kp_next;

    // output register
    logic                      ov_reg, ov_next;
    logic signed [DRV_W-1:0]   ms_reg, ms_next;
    logic                      otun_reg, otun_next;
    logic                      ofin_reg, ofin_next;
    logic                      ozero_reg, ozero_next;

    mul_req_t                  mreq;
    div_req_t                  dreq;
    logic                      mdone;
    logic                      ddone;
    logic [MUL_P_W-1:0]        prod;
    logic [DIV_N_W-1:0]        quo;

    logic signed [ERR_W-1:0]   err_in;
    logic [ERR_W-1:0]          err_mag;
    logic [DE_W-1:0]           de_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic [DT_W-1:0]           pu;
    logic signed [TERM_W-1:0]  inc64;
    logic signed [TERM_W-1:0]  sum64;
    logic signed [TERM_W-1:0]  term;
    logic signed [TERM_W-1:0]  u_mag;
    logic [TERM_W-1:0]         drv_shift;
    logic [DRV_W-1:0]          drv_mag;
    logic [TERM_W-1:0]         lim_scaled;
    logic [MUL_P_W-1:0]        gd_full;

    pwa_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .done    (mdone),
        .product (prod)
    );

    pwa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (ddone),
        .quotient (quo)
    );

    assign err_in  = ERR_W'(target_reg) - ERR_W'(angle);
    assign err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign de_mag  = de_reg[DE_W-1] ? DE_W'(-de_reg) : DE_W'(de_reg);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign pu      = zero_reg ? DT_W'(1) : dt_reg;
    assign u_mag   = u_reg[TERM_W-1] ? -u_reg : u_reg;
    assign drv_shift  = TERM_W'(u_mag) >> (GAIN_FRAC_BITS + 8);
    assign drv_mag    = (drv_shift > TERM_W'(DRIVE_LIMIT)) ? DRV_W'(DRIVE_LIMIT)
                                                           : drv_shift[DRV_W-1:0];
    assign lim_scaled = TERM_W'(limit_reg) << GAIN_FRAC_BITS;
    assign gd_full    = prod >> 3;

    // operand selection for the shared units
    always_comb
    begin
        mreq = '0;
        dreq = '0;
        case (state_reg)
            S_INC:
            begin
                mreq.start = 1'b1;
                mreq.a     = MUL_A_W'(err_mag);
                mreq.b     = MUL_B_W'(dt_reg);
            end
            S_P:
            begin
                mreq.start = 1'b1;
                mreq.a     = MUL_A_W'(err_mag);
                mreq.b     = gp_reg;
            end
            S_I:
            begin
                mreq.start = 1'b1;
                mreq.a     = sum_mag;
                mreq.b     = gi_reg;
            end
            S_DM:
            begin
                mreq.start = 1'b1;
                mreq.a     = MUL_A_W'(de_mag);
                mreq.b     = gd_reg;
            end
            S_DV:
            begin
                dreq.start = 1'b1;
                dreq.n     = prod[DIV_N_W-1:0];
                dreq.d     = dt_reg;
            end
            S_KP:
            begin
                dreq.start = 1'b1;
                dreq.n     = DIV_N_W'(tgain_reg) * DIV_N_W'(3);
                dreq.d     = DIV_D_W'(5);
            end
            S_GI:
            begin
                dreq.start = 1'b1;
                dreq.n     = DIV_N_W'(kp_reg) << 1;
                dreq.d     = pu;
            end
            S_GD:
            begin
                mreq.start = 1'b1;
                mreq.a     = MUL_A_W'(kp_reg);
                mreq.b     = MUL_B_W'(pu);
            end
            default:
            begin
                mreq = '0;
                dreq = '0;
            end
        endcase
    end

    always_comb
    begin
        target_next   = target_reg;
        limit_next    = limit_reg;
        tgain_next    = tgain_reg;
        tune_cfg_next = tune_cfg_reg;
        state_next    = state_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        gp_next       = gp_reg;
        gi_next       = gi_reg;
        gd_next       = gd_reg;
        tact_next     = tact_reg;
        err_next      = err_reg;
        de_next       = de_reg;
        dt_next       = dt_reg;
        zero_next     = zero_reg;
        was_tun_next  = was_tun_reg;
        fin_next      = fin_reg;
        u_next        = u_reg;
        kp_next       = kp_reg;
        ov_next       = ov_reg;
        ms_next       = ms_reg;
        otun_next     = otun_reg;
        ofin_next     = ofin_reg;
        ozero_next    = ozero_reg;
        inc64         = TERM_W'(prod[ERR_W+DT_W-1:0]);
        sum64         = '0;
        term          = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TARGET: target_next = cfg_data[ANGLE_W-1:0];
                CFG_LIMIT:  limit_next  = cfg_data[LIM_W-1:0];
                CFG_TGAIN:  tgain_next  = cfg_data[TG_W-1:0];
                CFG_TUNE:
                begin
                    tune_cfg_next = cfg_data[0];
                    tact_next     = cfg_data[0];
                end
                default: tune_cfg_next = tune_cfg_reg;
            endcase
        end

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    err_next     = err_in;
                    de_next      = DE_W'(err_in) - DE_W'(last_reg);
                    last_next    = err_in;
                    dt_next      = elapsed_ms;
                    zero_next    = (elapsed_ms == '0);
                    was_tun_next = tact_reg;
                    fin_next     = 1'b0;
                    if (tact_reg)
                        gp_next = GAIN_W'(tgain_reg);
                    state_next = S_INC;
                end
            end
            S_INC:  state_next = S_INC_W;
            S_INC_W:
            begin
                if (mdone)
                begin
                    // saturating integral update
                    sum64 = TERM_W'(sum_reg) + (err_reg[ERR_W-1] ? -inc64 : inc64);
                    if (sum64 > SUM_MAX)
                        sum_next = SUM_W'(SUM_MAX);
                    else if (sum64 < SUM_MIN)
                        sum_next = SUM_W'(SUM_MIN);
                    else
                        sum_next = SUM_W'(sum64);
                    state_next = S_P;
                end
            end
            S_P:    state_next = S_P_W;
            S_P_W:
            begin
                if (mdone)
                begin
                    term   = TERM_W'(prod[ERR_W+GAIN_W-1:0]);
                    u_next = err_reg[ERR_W-1] ? -term : term;
                    state_next = was_tun_reg ? S_CHK : S_I;
                end
            end
            S_I:    state_next = S_I_W;
            S_I_W:
            begin
                if (mdone)
                begin
                    if (prod > MUL_P_W'(TERM_LIM))
                        term = TERM_LIM;
                    else
                        term = TERM_W'(prod[TERM_W-1:0]);
                    if (sum_reg[SUM_W-1])
                        term = -term;
                    u_next = clamp_term(u_reg + term);
                    state_next = zero_reg ? S_CHK : S_DM;
                end
            end
            S_DM:   state_next = S_DM_W;
            S_DM_W:
            begin
                if (mdone)
                    state_next = S_DV;
            end
            S_DV:   state_next = S_DV_W;
            S_DV_W:
            begin
                if (ddone)
                begin
                    term = TERM_W'(quo);
                    if (de_reg[DE_W-1])
                        term = -term;
                    u_next = clamp_term(u_reg + term);
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (was_tun_reg && (TERM_W'(u_mag) > lim_scaled))
                    state_next = S_KP;
                else
                    state_next = S_OUT;
            end
            S_KP:   state_next = S_KP_W;
            S_KP_W:
            begin
                if (ddone)
                begin
                    kp_next    = quo[TG_W-1:0];
                    state_next = S_GI;
                end
            end
            S_GI:   state_next = S_GI_W;
            S_GI_W:
            begin
                if (ddone)
                begin
                    gi_next    = (quo > DIV_N_W'(GAIN_MAX)) ? GAIN_MAX : quo[GAIN_W-1:0];
                    state_next = S_GD;
                end
            end
            S_GD:   state_next = S_GD_W;
            S_GD_W:
            begin
                if (mdone)
                begin
                    gd_next    = (gd_full > MUL_P_W'(GAIN_MAX)) ? GAIN_MAX
                                                                : gd_full[GAIN_W-1:0];
                    gp_next    = GAIN_W'(kp_reg);
                    tact_next  = 1'b0;
                    fin_next   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ms_next    = u_reg[TERM_W-1] ? -DRV_W'(drv_mag) : DRV_W'(drv_mag);
                    otun_next  = was_tun_reg;
                    ofin_next  = fin_reg;
                    ozero_next = zero_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            limit_reg    <= LIM_RESET;
            tgain_reg    <= TG_RESET;
            tune_cfg_reg <= 1'b1;
            state_reg    <= S_IDLE;
            sum_reg      <= '0;
            last_reg     <= '0;
            gp_reg       <= GAIN_W'(TG_RESET);
            gi_reg       <= '0;
            gd_reg       <= '0;
            tact_reg     <= 1'b1;
            ov_reg       <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            limit_reg    <= limit_next;
            tgain_reg    <= tgain_next;
            tune_cfg_reg <= tune_cfg_next;
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            last_reg     <= last_next;
            gp_reg       <= gp_next;
            gi_reg       <= gi_next;
            gd_reg       <= gd_next;
            tact_reg     <= tact_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        de_reg      <= de_next;
        dt_reg      <= dt_next;
        zero_reg    <= zero_next;
        was_tun_reg <= was_tun_next;
        fin_reg     <= fin_next;
        u_reg       <= u_next;
        kp_reg      <= kp_next;
        ms_reg      <= ms_next;
        otun_reg    <= otun_next;
        ofin_reg    <= ofin_next;
        ozero_reg   <= ozero_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign motor_speed   = ms_reg;
    assign tuning        = otun_reg;
    assign tune_finished = ofin_reg;
    assign zero_interval = ozero_reg;

`ifndef SYNTHESIS
    a_fin_needs_tuning: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!tune_finished || tuning))
        else $error("tune_finished without tuning");
    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_speed != -DRV_W'(DRIVE_LIMIT + 1)))
        else $error("drive outside limit");
    a_fin_leaves_tuning: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && fin_reg) |-> !tact_reg)
        else $error("tuning still active after gains set");
`endif

endmodule

[hw/rtl/pwa_mul.sv]
`timescale 1ns / 1ps
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on pwa_pkg.
module pwa_mul
    import pwa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_P_W-1:0]   prod_reg, prod_next;
    logic [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_A_W:0]     upper;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        a_next    = a_reg;
        upper     = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
                  + (prod_reg[0] ? {1'b0, a_reg} : {(MUL_A_W+1){1'b0}});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            prod_next = {{MUL_A_W{1'b0}}, req.b};
            a_next    = req.a;
        end
        else if (busy_reg)
        begin
            // add the partial product to the upper half, then shift right
            prod_next = {upper, prod_reg[MUL_B_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");
`endif

endmodule

[hw/rtl/pwa_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pwa_pkg.
module pwa_div
    import pwa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   n_reg, n_next;
    logic [DIV_D_W-1:0]   d_reg, d_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, n_reg[DIV_N_W-1]};
        diff      = trial - {1'b0, d_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = req.n;
            d_next    = req.d;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in behind the consumed dividend bits
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = diff[DIV_D_W-1:0];
                n_next   = {n_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_D_W-1:0];
                n_next   = {n_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = n_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.d != '0)
        else $error("divider started with zero divisor");
`endif

endmodule
